/* hdl/kams_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kams_pkg
// Types and constants of the keyed adjacency matrix store.
// ----------------------------------------------------------------------------
package kams_pkg;

    localparam int FIELD_W = 32;

    localparam logic signed [FIELD_W-1:0] ABSENT_WEIGHT = 32'sd1000000000;

    localparam logic [2:0] FN_ADD_NODE   = 3'd0;
    localparam logic [2:0] FN_REM_NODE   = 3'd1;
    localparam logic [2:0] FN_ADD_EDGE   = 3'd2;
    localparam logic [2:0] FN_REM_EDGE   = 3'd3;
    localparam logic [2:0] FN_QUERY_NODE = 3'd4;
    localparam logic [2:0] FN_QUERY_EDGE = 3'd5;
    localparam logic [2:0] FN_LIST       = 3'd6;
    localparam logic [2:0] FN_RESERVED   = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]                func;
        logic [FIELD_W-1:0]        key_a;
        logic [FIELD_W-1:0]        key_b;
        logic signed [FIELD_W-1:0] weight;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic                      found;
        logic [FIELD_W-1:0]        neighbour_key;
        logic signed [FIELD_W-1:0] neighbour_weight;
        logic                      last;
    } rsp_t;

endpackage

/* hdl/keyed_adjacency_matrix_store_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_adjacency_matrix_store_core
// Directed weighted graph store on keyed node slots with an adjacency matrix.
// ----------------------------------------------------------------------------
// One operation at a time. Every operation first walks the used slots through
// the key RAM. Add node and remove node then sweep the slot's row and column
// in the matrix RAM, one write a cycle; a new slot's row and column are
// initialized by that sweep, so no clearing pass follows reset. Listing
// reads each used slot and then checks it, waiting while the result side
// stalls. Results leave through an output register, so a new request is
// taken while the final result still waits.
module keyed_adjacency_matrix_store_core #(
    parameter int MAX_NODES = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  kams_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output kams_pkg::rsp_t rsp
);
    import kams_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int AW = 2 * IW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SWEEP, S_EDGE_RD, S_EDGE_CHK,
        S_LIST_RD, S_LIST_CHK, S_LIST_END, S_RESP
    } state_t;

    state_t         state_reg;
    req_t           req_reg;
    logic [CW-1:0]  used_reg;
    logic [CW-1:0]  cnt_reg;
    logic [MAX_NODES-1:0] live_reg;
    logic           pend_reg;
    logic [IW-1:0]  pend_idx_reg;
    logic           a_hit_reg;
    logic           b_hit_reg;
    logic [IW-1:0]  a_idx_reg;
    logic [IW-1:0]  b_idx_reg;
    logic           phase_reg;
    logic           sweep_add_reg;
    logic           have_reg;
    logic [KW-1:0]  held_key_reg;
    logic signed [FIELD_W-1:0] held_w_reg;
    logic [1:0]     res_status_reg;
    logic           res_found_reg;
    logic           rsp_valid_reg;
    rsp_t           rsp_reg;

    logic [IW-1:0]  ci;
    logic           out_free;
    logic           rsp_load;
    logic [KW-1:0]  key_q;
    logic           key_we;
    logic [FIELD_W-1:0] edge_q_raw;
    logic signed [FIELD_W-1:0] edge_q;
    logic           edge_we;
    logic [AW-1:0]  edge_waddr;
    logic [AW-1:0]  edge_raddr;
    logic signed [FIELD_W-1:0] edge_wdata;
    logic           list_match;
    logic           is_edge_op;

    assign ci         = cnt_reg[IW-1:0];
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign edge_q     = edge_q_raw;
    assign list_match = live_reg[ci] && (edge_q != ABSENT_WEIGHT);
    assign is_edge_op = (req_reg.func == FN_ADD_EDGE) || (req_reg.func == FN_REM_EDGE);

    assign rsp_load = ((state_reg == S_LIST_CHK) && list_match && have_reg && out_free)
                      || (((state_reg == S_LIST_END) || (state_reg == S_RESP)) && out_free);

    assign key_we = (state_reg == S_DECIDE) && (req_reg.func == FN_ADD_NODE)
                    && (used_reg < CW'(MAX_NODES)) && !a_hit_reg;

    assign edge_we = (state_reg == S_SWEEP)
                     || ((state_reg == S_DECIDE) && is_edge_op && a_hit_reg && b_hit_reg);

    always_comb
    begin
        if (state_reg == S_SWEEP)
        begin
            edge_waddr = phase_reg ? {ci, a_idx_reg} : {a_idx_reg, ci};
            edge_wdata = (sweep_add_reg && (ci == a_idx_reg)) ? '0 : ABSENT_WEIGHT;
        end
        else
        begin
            edge_waddr = {a_idx_reg, b_idx_reg};
            edge_wdata = (req_reg.func == FN_ADD_EDGE) ? req_reg.weight : ABSENT_WEIGHT;
        end
        if ((state_reg == S_EDGE_RD) || (state_reg == S_EDGE_CHK))
        begin
            edge_raddr = {a_idx_reg, b_idx_reg};
        end
        else
        begin
            edge_raddr = {a_idx_reg, ci};
        end
    end

    kams_ram #(.AW(IW), .DW(KW)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[IW-1:0]),
        .wdata (req_reg.key_a[KW-1:0]),
        .raddr (ci),
        .rdata (key_q)
    );

    kams_ram #(.AW(AW), .DW(FIELD_W)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_q_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            used_reg       <= '0;
            cnt_reg        <= '0;
            live_reg       <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            a_hit_reg      <= 1'b0;
            b_hit_reg      <= 1'b0;
            a_idx_reg      <= '0;
            b_idx_reg      <= '0;
            phase_reg      <= 1'b0;
            sweep_add_reg  <= 1'b0;
            have_reg       <= 1'b0;
            held_key_reg   <= '0;
            held_w_reg     <= '0;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid && (req.func != FN_RESERVED))
                    begin
                        req_reg   <= req;
                        cnt_reg   <= '0;
                        pend_reg  <= 1'b0;
                        a_hit_reg <= 1'b0;
                        b_hit_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (pend_reg && live_reg[pend_idx_reg])
                    begin
                        if (!a_hit_reg && (key_q == req_reg.key_a[KW-1:0]))
                        begin
                            a_hit_reg <= 1'b1;
                            a_idx_reg <= pend_idx_reg;
                        end
                        if (!b_hit_reg && (key_q == req_reg.key_b[KW-1:0]))
                        begin
                            b_hit_reg <= 1'b1;
                            b_idx_reg <= pend_idx_reg;
                        end
                    end
                    if (cnt_reg < used_reg)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= ci;
                        cnt_reg      <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= 1'b0;
                    have_reg  <= 1'b0;
                    unique case (req_reg.func)
                        FN_ADD_NODE:
                        begin
                            res_found_reg <= 1'b0;
                            if (used_reg >= CW'(MAX_NODES))
                            begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_RESP;
                            end
                            else if (a_hit_reg)
                            begin
                                res_status_reg <= ST_DUPLICATE;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                res_status_reg <= ST_OK;
                                live_reg[used_reg[IW-1:0]] <= 1'b1;
                                a_idx_reg     <= used_reg[IW-1:0];
                                used_reg      <= used_reg + 1'b1;
                                sweep_add_reg <= 1'b1;
                                state_reg     <= S_SWEEP;
                            end
                        end
                        FN_REM_NODE:
                        begin
                            res_found_reg <= 1'b0;
                            if (!a_hit_reg)
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                res_status_reg <= ST_OK;
                                live_reg[a_idx_reg] <= 1'b0;
                                sweep_add_reg <= 1'b0;
                                state_reg     <= S_SWEEP;
                            end
                        end
                        FN_ADD_EDGE, FN_REM_EDGE:
                        begin
                            res_found_reg  <= 1'b0;
                            res_status_reg <= (a_hit_reg && b_hit_reg) ? ST_OK : ST_NOT_FOUND;
                            state_reg      <= S_RESP;
                        end
                        FN_QUERY_NODE:
                        begin
                            res_status_reg <= ST_OK;
                            res_found_reg  <= a_hit_reg;
                            state_reg      <= S_RESP;
                        end
                        FN_QUERY_EDGE:
                        begin
                            res_status_reg <= ST_OK;
                            res_found_reg  <= 1'b0;
                            state_reg      <= (a_hit_reg && b_hit_reg) ? S_EDGE_RD : S_RESP;
                        end
                        FN_LIST:
                        begin
                            res_found_reg <= 1'b0;
                            if (!a_hit_reg)
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SWEEP:
                begin
                    if (cnt_reg == CW'(MAX_NODES - 1))
                    begin
                        cnt_reg <= '0;
                        if (phase_reg)
                        begin
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            phase_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_EDGE_RD:
                begin
                    state_reg <= S_EDGE_CHK;
                end
                S_EDGE_CHK:
                begin
                    res_found_reg <= (edge_q != ABSENT_WEIGHT);
                    state_reg     <= S_RESP;
                end
                S_LIST_RD:
                begin
                    if (cnt_reg == used_reg)
                    begin
                        state_reg <= S_LIST_END;
                    end
                    else
                    begin
                        state_reg <= S_LIST_CHK;
                    end
                end
                S_LIST_CHK:
                begin
                    if (!list_match || !have_reg || out_free)
                    begin
                        if (list_match)
                        begin
                            if (have_reg)
                            begin
                                rsp_reg.status           <= ST_OK;
                                rsp_reg.found            <= 1'b1;
                                rsp_reg.neighbour_key    <= FIELD_W'(held_key_reg);
                                rsp_reg.neighbour_weight <= held_w_reg;
                                rsp_reg.last             <= 1'b0;
                            end
                            have_reg     <= 1'b1;
                            held_key_reg <= key_q;
                            held_w_reg   <= edge_q;
                        end
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_LIST_RD;
                    end
                end
                S_LIST_END:
                begin
                    if (out_free)
                    begin
                        rsp_reg.status           <= ST_OK;
                        rsp_reg.found            <= have_reg;
                        rsp_reg.neighbour_key    <= have_reg ? FIELD_W'(held_key_reg) : '0;
                        rsp_reg.neighbour_weight <= have_reg ? held_w_reg : '0;
                        rsp_reg.last             <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        rsp_reg.status           <= res_status_reg;
                        rsp_reg.found            <= res_found_reg;
                        rsp_reg.neighbour_key    <= '0;
                        rsp_reg.neighbour_weight <= '0;
                        rsp_reg.last             <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_NODES))
        else $error("slot count beyond table size");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(live_reg) <= int'(used_reg))
        else $error("more live slots than slots handed out");

    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("key write without slot advance");

    a_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.last) |-> (rsp_reg.found && (rsp_reg.status == ST_OK)))
        else $error("non-final transfer is not a neighbour");

endmodule

/* hdl/kams_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kams_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kams_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* test/graph_store_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_store_checker
// Watches both channels of the graph store, keeps its own copy of the node
// table and weight matrix, predicts every response and compares in order.
// ----------------------------------------------------------------------------
module graph_store_checker
    import kams_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    logic [FIELD_W-1:0]        node_key_mem [MAX_NODES];
    logic                      node_alive   [MAX_NODES];
    int                        used_slots;
    logic signed [FIELD_W-1:0] weight_mem   [MAX_NODES][MAX_NODES];
    rsp_t                      rsp_queue[$];

    assign pending = rsp_queue.size();

    function automatic int lookup_slot(logic [FIELD_W-1:0] key);
        for (int i = 0; i < used_slots; i++)
            if (node_alive[i] && node_key_mem[i] == key)
                return i;
        return -1;
    endfunction

    function automatic rsp_t make_rsp(logic [1:0] st, logic fnd, logic [FIELD_W-1:0] k,
                                      logic signed [FIELD_W-1:0] w, logic lst);
        rsp_t r;
        r.status = st;
        r.found = fnd;
        r.neighbour_key = k;
        r.neighbour_weight = w;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_graph_op(req_t q);
        int a;
        int b;
        int n;
        a = lookup_slot(q.key_a);
        b = lookup_slot(q.key_b);
        case (q.func)
            FN_ADD_NODE:
            begin
                if (used_slots >= MAX_NODES)
                    rsp_queue.push_back(make_rsp(ST_FULL, 1'b0, '0, '0, 1'b1));
                else if (a >= 0)
                    rsp_queue.push_back(make_rsp(ST_DUPLICATE, 1'b0, '0, '0, 1'b1));
                else
                begin
                    node_key_mem[used_slots] = q.key_a;
                    node_alive[used_slots] = 1'b1;
                    used_slots++;
                    rsp_queue.push_back(make_rsp(ST_OK, 1'b0, '0, '0, 1'b1));
                end
            end
            FN_REM_NODE:
            begin
                if (a < 0)
                    rsp_queue.push_back(make_rsp(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1));
                else
                begin
                    node_alive[a] = 1'b0;
                    for (int i = 0; i < MAX_NODES; i++)
                    begin
                        weight_mem[a][i] = ABSENT_WEIGHT;
                        weight_mem[i][a] = ABSENT_WEIGHT;
                    end
                    rsp_queue.push_back(make_rsp(ST_OK, 1'b0, '0, '0, 1'b1));
                end
            end
            FN_ADD_EDGE, FN_REM_EDGE:
            begin
                if (a < 0 || b < 0)
                    rsp_queue.push_back(make_rsp(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1));
                else
                begin
                    weight_mem[a][b] = (q.func == FN_ADD_EDGE) ? q.weight : ABSENT_WEIGHT;
                    rsp_queue.push_back(make_rsp(ST_OK, 1'b0, '0, '0, 1'b1));
                end
            end
            FN_QUERY_NODE:
                rsp_queue.push_back(make_rsp(ST_OK, a >= 0, '0, '0, 1'b1));
            FN_QUERY_EDGE:
                rsp_queue.push_back(make_rsp(ST_OK,
                    a >= 0 && b >= 0 && weight_mem[a][b] != ABSENT_WEIGHT, '0, '0, 1'b1));
            FN_LIST:
            begin
                if (a < 0)
                    rsp_queue.push_back(make_rsp(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1));
                else
                begin
                    n = 0;
                    for (int i = 0; i < used_slots; i++)
                        if (node_alive[i] && weight_mem[a][i] != ABSENT_WEIGHT)
                        begin
                            rsp_queue.push_back(make_rsp(ST_OK, 1'b1, node_key_mem[i],
                                                         weight_mem[a][i], 1'b0));
                            n++;
                        end
                    if (n == 0)
                        rsp_queue.push_back(make_rsp(ST_OK, 1'b0, '0, '0, 1'b1));
                    else
                        rsp_queue[$].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            used_slots = 0;
            fail_count <= 0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                node_key_mem[i] = '0;
                node_alive[i] = 1'b0;
                for (int j = 0; j < MAX_NODES; j++)
                    weight_mem[i][j] = (i == j) ? '0 : ABSENT_WEIGHT;
            end
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected response %p", rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_rsp = rsp_queue.pop_front();
                    if (rsp !== exp_rsp)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_rsp, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_valid && req_ready)
                predict_graph_op(req);
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random graph operations into the store with random
// gaps and back-pressure, including one long receiver hold-off, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
    import kams_pkg::*;

    localparam int MAX_NODES = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    logic stim_done = 1'b0;
    logic [FIELD_W-1:0] key_pool[16];

    always #1 clk = ~clk;

    keyed_adjacency_matrix_store_core #(.MAX_NODES(MAX_NODES), .KEY_BITS(32)) u_top (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    graph_store_checker #(.MAX_NODES(MAX_NODES)) u_checker (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_op(logic [2:0] fn, logic [FIELD_W-1:0] ka,
                           logic [FIELD_W-1:0] kb, logic signed [FIELD_W-1:0] w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_valid <= 1'b1;
        req.func <= fn;
        req.key_a <= ka;
        req.key_b <= kb;
        req.weight <= w;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, 15)];
    endfunction

    initial
    begin
        int stall;
        @(posedge rst_n);
        repeat (200) @(negedge clk);
        stall = 0;
        while (stall < 600)
        begin
            @(negedge clk);
            stall++;
        end
        forever
        begin
            @(negedge clk);
            if (stim_done || $urandom_range(0, 3) != 0)
                rsp_ready <= 1'b1;
            else
            begin
                rsp_ready <= 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [2:0] fn;
        logic signed [FIELD_W-1:0] w;
        int r;
        for (int i = 0; i < 16; i++)
            key_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_op(FN_LIST, 32'h0, 32'h0, 0);
        send_op(FN_ADD_NODE, 32'h0, 32'h0, 0);
        send_op(FN_ADD_NODE, 32'hFFFF_FFFF, 32'h0, 0);
        send_op(FN_ADD_NODE, 32'hFFFF_FFFF, 32'h0, 0);
        send_op(FN_ADD_EDGE, 32'h0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_op(FN_ADD_EDGE, 32'hFFFF_FFFF, 32'h0, 32'sh8000_0000);
        send_op(FN_ADD_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ABSENT_WEIGHT);
        send_op(FN_ADD_EDGE, 32'h0, 32'h1234, 5);
        send_op(FN_QUERY_NODE, 32'h0, 32'h0, 0);
        send_op(FN_QUERY_NODE, 32'h55, 32'h0, 0);
        send_op(FN_QUERY_EDGE, 32'h0, 32'hFFFF_FFFF, 0);
        send_op(FN_QUERY_EDGE, 32'h0, 32'h77, 0);
        send_op(FN_LIST, 32'h0, 32'h0, 0);
        send_op(FN_LIST, 32'hFFFF_FFFF, 32'h0, 0);
        send_op(FN_LIST, 32'h99, 32'h0, 0);
        send_op(FN_REM_EDGE, 32'h0, 32'hFFFF_FFFF, 0);
        send_op(FN_REM_EDGE, 32'h99, 32'h0, 0);
        send_op(FN_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1);
        send_op(FN_REM_NODE, 32'hFFFF_FFFF, 32'h0, 0);
        send_op(FN_REM_NODE, 32'hFFFF_FFFF, 32'h0, 0);
        send_op(FN_LIST, 32'h0, 32'h0, 0);
        for (int i = 0; i < 160; i++)
        begin
            r = $urandom_range(0, 99);
            fn = r < 25 ? FN_ADD_NODE : r < 32 ? FN_REM_NODE : r < 55 ? FN_ADD_EDGE :
                 r < 62 ? FN_REM_EDGE : r < 70 ? FN_QUERY_NODE : r < 78 ? FN_QUERY_EDGE :
                 r < 97 ? FN_LIST : FN_RESERVED;
            w = ($urandom_range(0, 19) == 0) ? ABSENT_WEIGHT : $urandom();
            if (fn == FN_ADD_NODE && $urandom_range(0, 2) == 0)
                send_op(fn, $urandom(), 32'h0, w);
            else
                send_op(fn, pick_key(), pick_key(), w);
        end
        for (int i = 0; i < 70; i++)
            send_op(FN_ADD_NODE, $urandom(), 32'h0, 0);
        for (int i = 0; i < 5; i++)
            send_op(FN_LIST, key_pool[$urandom_range(0, 15)], 32'h0, 0);
        req_valid <= 1'b0;
        stim_done <= 1'b1;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
